>>> sv/tnrn_pkg.sv
// Shared types, byte codes and reset constants for the telnet receive negotiator.
`default_nettype none

package tnrn_pkg;

   // Table size and register reset values
   localparam int          NUM_OPTIONS_DEF   = 64;
   localparam logic [63:0] WE_CAN_RESET      = 64'd4311744617;
   localparam logic [63:0] THEY_SHOULD_RESET = 64'd107;

   // Telnet byte codes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_DM   = 8'd242;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_CR   = 8'd13;
   localparam logic [7:0] B_NUL  = 8'd0;

   // Item opcodes
   localparam logic [2:0] OP_RX   = 3'd0;
   localparam logic [2:0] OP_DO   = 3'd1;
   localparam logic [2:0] OP_DONT = 3'd2;
   localparam logic [2:0] OP_WILL = 3'd3;
   localparam logic [2:0] OP_WONT = 3'd4;

   // Register indexes
   localparam logic CSR_WE_CAN      = 1'b0;
   localparam logic CSR_THEY_SHOULD = 1'b1;

   // Per-option negotiation state (Q method)
   typedef enum logic [2:0] {
      OPT_NO       = 3'd0,
      OPT_YES      = 3'd1,
      OPT_WANTNO   = 3'd2,
      OPT_WANTNOQ  = 3'd3,
      OPT_WANTYES  = 3'd4,
      OPT_WANTYESQ = 3'd5
   } opt_st_type;

   // Receive parser state
   typedef enum logic [3:0] {
      PS_NORMAL = 4'd0,
      PS_CR     = 4'd1,
      PS_IAC    = 4'd2,
      PS_DO     = 4'd3,
      PS_DONT   = 4'd4,
      PS_WILL   = 4'd5,
      PS_WONT   = 4'd6,
      PS_SUB    = 4'd7,
      PS_SUBIAC = 4'd8
   } ps_type;

   // Write-back to one option table
   typedef struct packed {
      logic       en;
      opt_st_type st;
   } tbl_wr_type;

   // One result item
   typedef struct packed {
      logic       valid;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       send_valid;
      logic [7:0] send_command;
      logic [7:0] send_option;
      logic       request_done;
      logic       request_ok;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/telnet_receive_negotiator.sv
// Top level: input stage, option tables, decision stage and result register.
// An accepted item is held in the input stage; its result is held in the result register.
// Throughput: one item per cycle unless the result output stalls; each item does one
// read-modify-write of an option table (registered read, bypass of the last item's write).
// Reset: synchronous, clears parser state, pipeline, registers to defaults and the
// table valid bits; no clearing pass, items are taken right after reset.
`default_nettype none

module telnet_receive_negotiator #(
   parameter int NUM_OPTIONS = tnrn_pkg::NUM_OPTIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Item input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [7:0]  req_option_code,
   // Result output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_data_valid,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_send_valid,
   output logic [7:0]       rsp_send_command,
   output logic [7:0]       rsp_send_option,
   output logic             rsp_request_done,
   output logic             rsp_request_ok,
   // Register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int AW = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1;

   logic                 req_acc;
   logic                 s1_fire;
   logic                 s1_valid_ff;
   logic [2:0]           s1_op_ff;
   logic [7:0]           s1_rx_ff;
   logic [7:0]           s1_opt_ff;
   logic [7:0]           s0_byte;
   logic [7:0]           s1_byte;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   tnrn_pkg::ps_type     parse_ff;
   tnrn_pkg::ps_type     parse_in;
   logic                 their0_yes_ff;
   logic [63:0]          we_can_ff;
   logic [63:0]          they_should_ff;
   tnrn_pkg::opt_st_type our_st;
   tnrn_pkg::opt_st_type their_st;
   tnrn_pkg::tbl_wr_type our_wr;
   tnrn_pkg::tbl_wr_type their_wr;
   tnrn_pkg::rsp_type    res;
   logic                 rsp_valid_ff;
   tnrn_pkg::rsp_type    res_ff;

   // Handshakes
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Table address: option byte of a received byte or of a local request
   assign s0_byte = (req_opcode == tnrn_pkg::OP_RX) ? req_rx_byte : req_option_code;
   assign rd_addr = s0_byte[AW-1:0];
   assign s1_byte = (s1_op_ff == tnrn_pkg::OP_RX) ? s1_rx_ff : s1_opt_ff;
   assign wr_addr = s1_byte[AW-1:0];

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_acc) begin
         s1_op_ff  <= req_opcode;
         s1_rx_ff  <= req_rx_byte;
         s1_opt_ff <= req_option_code;
      end
   end

   tnrn_opt_mem #(
      .NUM_OPTIONS (NUM_OPTIONS),
      .AW          (AW)
   ) u_our_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_acc),
      .rd_addr  (rd_addr),
      .wr_en    (s1_fire && our_wr.en),
      .wr_addr  (wr_addr),
      .wr_data  (our_wr.st),
      .rd_state (our_st)
   );

   tnrn_opt_mem #(
      .NUM_OPTIONS (NUM_OPTIONS),
      .AW          (AW)
   ) u_their_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_acc),
      .rd_addr  (rd_addr),
      .wr_en    (s1_fire && their_wr.en),
      .wr_addr  (wr_addr),
      .wr_data  (their_wr.st),
      .rd_state (their_st)
   );

   tnrn_step #(
      .NUM_OPTIONS (NUM_OPTIONS)
   ) u_step (
      .parse            (parse_ff),
      .opcode           (s1_op_ff),
      .rx_byte          (s1_rx_ff),
      .option_code      (s1_opt_ff),
      .our_st           (our_st),
      .their_st         (their_st),
      .their0_yes       (their0_yes_ff),
      .we_can_mask      (we_can_ff),
      .they_should_mask (they_should_ff),
      .parse_in         (parse_in),
      .our_wr           (our_wr),
      .their_wr         (their_wr),
      .res              (res)
   );

   // Parser state and shadow of peer binary (their option 0 is yes)
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff      <= tnrn_pkg::PS_NORMAL;
         their0_yes_ff <= 1'b0;
      end else if (s1_fire) begin
         parse_ff <= parse_in;
         if (their_wr.en && (s1_byte == 8'd0)) begin
            their0_yes_ff <= (their_wr.st == tnrn_pkg::OPT_YES);
         end
      end
   end

   // Permission masks
   always_ff @(posedge clock) begin
      if (reset) begin
         we_can_ff      <= tnrn_pkg::WE_CAN_RESET;
         they_should_ff <= tnrn_pkg::THEY_SHOULD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tnrn_pkg::CSR_WE_CAN:      we_can_ff      <= csr_data;
            tnrn_pkg::CSR_THEY_SHOULD: they_should_ff <= csr_data;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= res.valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_fire && res.valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_valid   = res_ff.data_valid;
   assign rsp_data_byte    = res_ff.data_byte;
   assign rsp_send_valid   = res_ff.send_valid;
   assign rsp_send_command = res_ff.send_command;
   assign rsp_send_option  = res_ff.send_option;
   assign rsp_request_done = res_ff.request_done;
   assign rsp_request_ok   = res_ff.request_ok;

`ifndef SYNTHESIS
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_no_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (res_ff.data_valid || res_ff.send_valid || res_ff.request_done))
      else $error("result item carries nothing");

   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.data_valid |-> !res_ff.send_valid && !res_ff.request_done)
      else $error("data byte mixed with command or request answer");

   a_send_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.send_valid |->
         (res_ff.send_command == tnrn_pkg::B_WILL) || (res_ff.send_command == tnrn_pkg::B_WONT) ||
         (res_ff.send_command == tnrn_pkg::B_DO) || (res_ff.send_command == tnrn_pkg::B_DONT))
      else $error("bad negotiation command");

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.request_ok |-> res_ff.request_done)
      else $error("request_ok without request_done");
`endif

endmodule

`default_nettype wire

>>> sv/tnrn_opt_mem.sv
// Option state table: synchronous memory with per-entry valid bits and write bypass.
`default_nettype none

module tnrn_opt_mem #(
   parameter int NUM_OPTIONS = tnrn_pkg::NUM_OPTIONS_DEF,
   parameter int AW          = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire tnrn_pkg::opt_st_type wr_data,
   output tnrn_pkg::opt_st_type      rd_state
);

   tnrn_pkg::opt_st_type mem [NUM_OPTIONS];
   logic [NUM_OPTIONS-1:0] valid_ff;
   tnrn_pkg::opt_st_type   rdata_ff;
   logic [AW-1:0]          rd_addr_ff;
   logic                   byp_hit_ff;
   tnrn_pkg::opt_st_type   byp_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Valid bits: an entry never written reads as no
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Read port, registered; catch a write to the same entry in the read cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         rd_addr_ff  <= rd_addr;
         byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_state = byp_hit_ff ? byp_data_ff :
                     (valid_ff[rd_addr_ff] ? rdata_ff : tnrn_pkg::OPT_NO);

endmodule

`default_nettype wire

>>> sv/tnrn_step.sv
// Per-item decision: receive parser, peer negotiation and local requests.
`default_nettype none

module tnrn_step #(
   parameter int NUM_OPTIONS = tnrn_pkg::NUM_OPTIONS_DEF
) (
   input  wire tnrn_pkg::ps_type     parse,
   input  wire logic [2:0]           opcode,
   input  wire logic [7:0]           rx_byte,
   input  wire logic [7:0]           option_code,
   input  wire tnrn_pkg::opt_st_type our_st,
   input  wire tnrn_pkg::opt_st_type their_st,
   input  wire logic                 their0_yes,
   input  wire logic [63:0]          we_can_mask,
   input  wire logic [63:0]          they_should_mask,
   output tnrn_pkg::ps_type          parse_in,
   output tnrn_pkg::tbl_wr_type      our_wr,
   output tnrn_pkg::tbl_wr_type      their_wr,
   output tnrn_pkg::rsp_type         res
);

   typedef struct packed {
      tnrn_pkg::opt_st_type st;
      logic                 send;
      logic                 pos;
      logic                 ok;
   } act_type;

   // Peer sent DO/WILL (enable) or DONT/WONT (disable)
   function automatic act_type peer_fn(input logic en, input tnrn_pkg::opt_st_type cur,
                                       input logic permit);
      act_type a;
      a = '{st: cur, send: 1'b0, pos: 1'b0, ok: 1'b0};
      if (en) begin
         unique case (cur)
            tnrn_pkg::OPT_NO: begin
               a.send = 1'b1;
               if (permit) begin
                  a.st  = tnrn_pkg::OPT_YES;
                  a.pos = 1'b1;
               end
            end
            tnrn_pkg::OPT_WANTNO:   a.st = tnrn_pkg::OPT_NO;
            tnrn_pkg::OPT_WANTNOQ:  a.st = tnrn_pkg::OPT_YES;
            tnrn_pkg::OPT_WANTYES:  a.st = tnrn_pkg::OPT_YES;
            tnrn_pkg::OPT_WANTYESQ: begin
               a.st   = tnrn_pkg::OPT_WANTNO;
               a.send = 1'b1;
            end
            default: ;
         endcase
      end else begin
         unique case (cur)
            tnrn_pkg::OPT_YES: begin
               a.st   = tnrn_pkg::OPT_NO;
               a.send = 1'b1;
            end
            tnrn_pkg::OPT_WANTNO:   a.st = tnrn_pkg::OPT_NO;
            tnrn_pkg::OPT_WANTNOQ: begin
               a.st   = tnrn_pkg::OPT_WANTYES;
               a.send = 1'b1;
               a.pos  = 1'b1;
            end
            tnrn_pkg::OPT_WANTYES:  a.st = tnrn_pkg::OPT_NO;
            tnrn_pkg::OPT_WANTYESQ: a.st = tnrn_pkg::OPT_NO;
            default: ;
         endcase
      end
      return a;
   endfunction

   // Local enable/disable request
   function automatic act_type local_fn(input logic en, input tnrn_pkg::opt_st_type cur);
      act_type a;
      a = '{st: cur, send: 1'b0, pos: 1'b0, ok: 1'b0};
      if (en) begin
         unique case (cur)
            tnrn_pkg::OPT_NO: begin
               a.st   = tnrn_pkg::OPT_WANTYES;
               a.send = 1'b1;
               a.ok   = 1'b1;
            end
            tnrn_pkg::OPT_WANTNO: begin
               a.st = tnrn_pkg::OPT_WANTNOQ;
               a.ok = 1'b1;
            end
            tnrn_pkg::OPT_WANTNOQ:  a.st = tnrn_pkg::OPT_NO;
            tnrn_pkg::OPT_WANTYES:  a.st = tnrn_pkg::OPT_NO;
            tnrn_pkg::OPT_WANTYESQ: begin
               a.st = tnrn_pkg::OPT_WANTYES;
               a.ok = 1'b1;
            end
            default: ;
         endcase
      end else begin
         unique case (cur)
            tnrn_pkg::OPT_YES: begin
               a.st   = tnrn_pkg::OPT_WANTNO;
               a.send = 1'b1;
               a.ok   = 1'b1;
            end
            tnrn_pkg::OPT_WANTNO:   a.st = tnrn_pkg::OPT_NO;
            tnrn_pkg::OPT_WANTNOQ: begin
               a.st = tnrn_pkg::OPT_WANTNO;
               a.ok = 1'b1;
            end
            tnrn_pkg::OPT_WANTYES: begin
               a.st = tnrn_pkg::OPT_WANTYESQ;
               a.ok = 1'b1;
            end
            tnrn_pkg::OPT_WANTYESQ: a.st = tnrn_pkg::OPT_YES;
            default: ;
         endcase
      end
      return a;
   endfunction

   logic [7:0]           opt_byte;
   logic                 in_range;
   logic                 we_ok;
   logic                 they_ok;
   logic                 do_norm;
   logic                 do_iac;
   logic                 do_peer;
   logic                 peer_us;
   logic                 peer_en;
   logic                 loc_us;
   logic                 loc_en;
   tnrn_pkg::opt_st_type cur;
   act_type              act;

   always_comb begin
      parse_in = parse;
      our_wr   = '0;
      their_wr = '0;
      res      = '0;
      do_norm  = 1'b0;
      do_iac   = 1'b0;
      do_peer  = 1'b0;
      peer_us  = 1'b0;
      peer_en  = 1'b0;
      loc_us   = 1'b0;
      loc_en   = 1'b0;
      cur      = tnrn_pkg::OPT_NO;
      act      = '0;

      opt_byte = (opcode == tnrn_pkg::OP_RX) ? rx_byte : option_code;
      in_range = {1'b0, opt_byte} < 9'(NUM_OPTIONS);
      we_ok    = (opt_byte[7:6] == 2'b00) && we_can_mask[opt_byte[5:0]];
      they_ok  = (opt_byte[7:6] == 2'b00) && they_should_mask[opt_byte[5:0]];

      case (opcode)
         tnrn_pkg::OP_RX: begin
            // Parser dispatch
            unique case (parse)
               tnrn_pkg::PS_CR: begin
                  parse_in = tnrn_pkg::PS_NORMAL;
                  do_norm  = (rx_byte != tnrn_pkg::B_NUL);
               end
               tnrn_pkg::PS_NORMAL: do_norm = 1'b1;
               tnrn_pkg::PS_IAC:    do_iac  = 1'b1;
               tnrn_pkg::PS_DO: begin
                  parse_in = tnrn_pkg::PS_NORMAL;
                  do_peer  = 1'b1;
                  peer_us  = 1'b1;
                  peer_en  = 1'b1;
               end
               tnrn_pkg::PS_DONT: begin
                  parse_in = tnrn_pkg::PS_NORMAL;
                  do_peer  = 1'b1;
                  peer_us  = 1'b1;
               end
               tnrn_pkg::PS_WILL: begin
                  parse_in = tnrn_pkg::PS_NORMAL;
                  do_peer  = 1'b1;
                  peer_en  = 1'b1;
               end
               tnrn_pkg::PS_WONT: begin
                  parse_in = tnrn_pkg::PS_NORMAL;
                  do_peer  = 1'b1;
               end
               tnrn_pkg::PS_SUB: begin
                  if (rx_byte == tnrn_pkg::B_IAC) begin
                     parse_in = tnrn_pkg::PS_SUBIAC;
                  end
               end
               tnrn_pkg::PS_SUBIAC: begin
                  if (rx_byte == tnrn_pkg::B_SE) begin
                     parse_in = tnrn_pkg::PS_NORMAL;
                  end else if (rx_byte == tnrn_pkg::B_IAC) begin
                     parse_in = tnrn_pkg::PS_SUB;
                  end else begin
                     do_iac = 1'b1;
                  end
               end
               default: parse_in = tnrn_pkg::PS_NORMAL;
            endcase

            // Plain data byte
            if (do_norm) begin
               if (rx_byte == tnrn_pkg::B_IAC) begin
                  parse_in = tnrn_pkg::PS_IAC;
               end else begin
                  parse_in = (rx_byte == tnrn_pkg::B_CR && !their0_yes) ?
                             tnrn_pkg::PS_CR : tnrn_pkg::PS_NORMAL;
                  res.valid      = 1'b1;
                  res.data_valid = 1'b1;
                  res.data_byte  = rx_byte;
               end
            end

            // Command byte after IAC
            if (do_iac) begin
               case (rx_byte)
                  tnrn_pkg::B_IAC: begin
                     parse_in       = tnrn_pkg::PS_NORMAL;
                     res.valid      = 1'b1;
                     res.data_valid = 1'b1;
                     res.data_byte  = tnrn_pkg::B_IAC;
                  end
                  tnrn_pkg::B_DO:   parse_in = tnrn_pkg::PS_DO;
                  tnrn_pkg::B_DONT: parse_in = tnrn_pkg::PS_DONT;
                  tnrn_pkg::B_WILL: parse_in = tnrn_pkg::PS_WILL;
                  tnrn_pkg::B_WONT: parse_in = tnrn_pkg::PS_WONT;
                  tnrn_pkg::B_SB:   parse_in = tnrn_pkg::PS_SUB;
                  default:          parse_in = tnrn_pkg::PS_NORMAL;
               endcase
            end

            // Peer negotiation on our side (DO/DONT) or theirs (WILL/WONT)
            if (do_peer) begin
               if (!in_range) begin
                  if (peer_en) begin
                     res.valid        = 1'b1;
                     res.send_valid   = 1'b1;
                     res.send_command = peer_us ? tnrn_pkg::B_WONT : tnrn_pkg::B_DONT;
                     res.send_option  = opt_byte;
                  end
               end else begin
                  cur = peer_us ? our_st : their_st;
                  act = peer_fn(peer_en, cur, peer_us ? we_ok : they_ok);
                  if (peer_us) begin
                     our_wr = '{en: 1'b1, st: act.st};
                  end else begin
                     their_wr = '{en: 1'b1, st: act.st};
                  end
                  if (act.send) begin
                     res.valid        = 1'b1;
                     res.send_valid   = 1'b1;
                     res.send_option  = opt_byte;
                     if (peer_us) begin
                        res.send_command = act.pos ? tnrn_pkg::B_WILL : tnrn_pkg::B_WONT;
                     end else begin
                        res.send_command = act.pos ? tnrn_pkg::B_DO : tnrn_pkg::B_DONT;
                     end
                  end
               end
            end
         end

         tnrn_pkg::OP_DO, tnrn_pkg::OP_DONT, tnrn_pkg::OP_WILL, tnrn_pkg::OP_WONT: begin
            // Local request always answers
            loc_us = (opcode == tnrn_pkg::OP_WILL) || (opcode == tnrn_pkg::OP_WONT);
            loc_en = (opcode == tnrn_pkg::OP_DO) || (opcode == tnrn_pkg::OP_WILL);
            res.valid        = 1'b1;
            res.request_done = 1'b1;
            if (in_range) begin
               cur = loc_us ? our_st : their_st;
               act = local_fn(loc_en, cur);
               if (loc_us) begin
                  our_wr = '{en: 1'b1, st: act.st};
               end else begin
                  their_wr = '{en: 1'b1, st: act.st};
               end
               res.request_ok = act.ok;
               if (act.send) begin
                  res.send_valid  = 1'b1;
                  res.send_option = opt_byte;
                  case (opcode)
                     tnrn_pkg::OP_DO:   res.send_command = tnrn_pkg::B_DO;
                     tnrn_pkg::OP_DONT: res.send_command = tnrn_pkg::B_DONT;
                     tnrn_pkg::OP_WILL: res.send_command = tnrn_pkg::B_WILL;
                     default:           res.send_command = tnrn_pkg::B_WONT;
                  endcase
               end
            end
         end

         default: ;
      endcase
   end

endmodule

`default_nettype wire
